// ----- hw/rtl/dwsp_pkg.sv -----
// ----------------------------------------------------------------------------
// dwsp_pkg
// shared types and constants of the differential wheel speed pi controller
// ----------------------------------------------------------------------------
package dwsp_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_KP      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_KI      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_KI     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_KP      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY     = 3'd6;

  localparam int unsigned OP_W        = 18;
  localparam int unsigned PROD_W      = 2 * OP_W;
  localparam int unsigned Q8_SHIFT    = 8;
  localparam int unsigned BOOST_SHIFT = 8;

  localparam logic signed [OP_W-1:0] NEG_BOOST = 18'sd294;
  localparam logic signed [9:0]      BRAKE_HI  = 10'sd85;
  localparam logic signed [9:0]      BRAKE_LO  = -10'sd85;
  localparam logic [3:0]             CALM_LIMIT = 4'd10;

  typedef struct packed {
    logic [15:0] base_speed;
    logic [15:0] left_kp;
    logic [15:0] left_ki;
    logic [15:0] right_kp;
    logic [15:0] right_ki;
    logic [15:0] turn_kp;
    logic [14:0] max_duty;
  } dwsp_cfg_t;

  typedef struct packed {
    logic signed [9:0]  line_error;
    logic               turn_update;
    logic               ring_active;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic               left_dir_pin;
    logic               right_dir_pin;
  } dwsp_item_t;

  typedef struct packed {
    logic signed [15:0] left_duty;
    logic signed [15:0] right_duty;
    logic signed [15:0] steer_value;
    logic               braking;
  } dwsp_result_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } dwsp_status_t;

endpackage

// ----- hw/rtl/dwsp_mul.sv -----
// ----------------------------------------------------------------------------
// dwsp_mul
// shared signed 18x18 multiplier with registered product
// ----------------------------------------------------------------------------
module dwsp_mul (
  input  logic                                 clk,
  input  logic signed [dwsp_pkg::OP_W-1:0]     a,
  input  logic signed [dwsp_pkg::OP_W-1:0]     b,
  output logic signed [dwsp_pkg::PROD_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ----- hw/rtl/dwsp_seq.sv -----
// ----------------------------------------------------------------------------
// dwsp_seq
// sequencer and datapath: steering loop, brake flag, wheel targets and two
// incremental pi wheel loops, all through one shared multiplier
// ----------------------------------------------------------------------------
module dwsp_seq #(
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  dwsp_pkg::dwsp_item_t    item,
  input  dwsp_pkg::dwsp_cfg_t     cfg,
  input  logic                    res_ready,
  output dwsp_pkg::dwsp_status_t  status,
  output dwsp_pkg::dwsp_result_t  result
);

  localparam int unsigned F  = GAIN_FRAC_BITS;
  localparam int unsigned SH = (F >= dwsp_pkg::Q8_SHIFT) ? F - dwsp_pkg::Q8_SHIFT : 0;
  localparam int unsigned DS = (F >= dwsp_pkg::Q8_SHIFT) ? 0 : dwsp_pkg::Q8_SHIFT - F;
  localparam int unsigned SW = dwsp_pkg::PROD_W + 1;
  localparam int unsigned AW = SW + 1 + SH;
  localparam int unsigned QW = (F + 20 > 36) ? F + 20 : 36;
  localparam int unsigned OW = dwsp_pkg::OP_W;

  localparam logic [7:0]   DMASK = 8'((1 << DS) - 1);
  localparam logic [F-1:0] FMASK = '1;

  localparam logic signed [AW-1:0] S32_MAX = AW'(64'sh7FFF_FFFF);
  localparam logic signed [AW-1:0] S32_MIN = ~S32_MAX;
  localparam logic signed [QW-1:0] Q16_MAX = QW'(64'sh7FFF);
  localparam logic signed [QW-1:0] Q16_MIN = ~Q16_MAX;
  localparam logic signed [32:0]   P16_MAX = 33'sh7FFF;
  localparam logic signed [32:0]   P16_MIN = ~P16_MAX;

  localparam logic [4:0] ST_IDLE      = 5'd0;
  localparam logic [4:0] ST_STEER_OP  = 5'd1;
  localparam logic [4:0] ST_STEER_MUL = 5'd2;
  localparam logic [4:0] ST_STEER_SCL = 5'd3;
  localparam logic [4:0] ST_STEER_ACC = 5'd4;
  localparam logic [4:0] ST_TGT       = 5'd5;
  localparam logic [4:0] ST_ERR       = 5'd6;
  localparam logic [4:0] ST_ERRT      = 5'd7;
  localparam logic [4:0] ST_W_BOOST   = 5'd8;
  localparam logic [4:0] ST_W_BMUL    = 5'd9;
  localparam logic [4:0] ST_W_KPE     = 5'd10;
  localparam logic [4:0] ST_W_DIFF    = 5'd11;
  localparam logic [4:0] ST_W_IPROD   = 5'd12;
  localparam logic [4:0] ST_W_PSUM    = 5'd13;
  localparam logic [4:0] ST_W_SCALE   = 5'd14;
  localparam logic [4:0] ST_W_ACC     = 5'd15;
  localparam logic [4:0] ST_W_CLAMP   = 5'd16;
  localparam logic [4:0] ST_FIN       = 5'd17;

  // q8.8 product to q.f, truncating toward zero
  function automatic logic signed [AW-1:0] to_qf(input logic signed [SW-1:0] x);
    logic signed [AW-1:0] xe;
    logic signed [AW-1:0] bias;
    xe   = AW'(x);
    bias = x[SW-1] ? AW'(DMASK) : '0;
    return ((xe + bias) >>> DS) <<< SH;
  endfunction

  function automatic logic signed [QW-1:0] qdiv(input logic signed [QW-1:0] x);
    logic signed [QW-1:0] bias;
    bias = x[QW-1] ? QW'(FMASK) : '0;
    return (x + bias) >>> F;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [QW-1:0] x);
    logic signed [15:0] r;
    if (x > Q16_MAX) begin
      r = 16'sh7FFF;
    end else if (x < Q16_MIN) begin
      r = 16'sh8000;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [32:0] ipart(input logic signed [31:0] a);
    logic signed [32:0] ae;
    logic signed [32:0] bias;
    ae   = 33'(a);
    bias = a[31] ? 33'(FMASK) : '0;
    return (ae + bias) >>> F;
  endfunction

  logic [4:0]               state_r, state_nxt;
  logic                     w_r, w_nxt;
  logic signed [9:0]        e_r, e_nxt;
  logic                     upd_r, upd_nxt;
  logic                     ring_r, ring_nxt;
  logic signed [16:0]       lc_r, lc_nxt;
  logic signed [16:0]       rc_r, rc_nxt;
  logic signed [9:0]        steer_prev_r, steer_prev_nxt;
  logic signed [31:0]       steer_acc_r, steer_acc_nxt;
  logic signed [15:0]       lprev_r, lprev_nxt;
  logic signed [15:0]       rprev_r, rprev_nxt;
  logic signed [31:0]       lacc_r, lacc_nxt;
  logic signed [31:0]       racc_r, racc_nxt;
  logic                     brake_r, brake_nxt;
  logic [3:0]               calm_r, calm_nxt;
  logic signed [OW-1:0]     op_a_r, op_a_nxt;
  logic signed [OW-1:0]     op_b_r, op_b_nxt;
  logic signed [AW-1:0]     sc_r, sc_nxt;
  logic [15:0]              t_r, t_nxt;
  logic signed [QW-1:0]     tq_l_r, tq_l_nxt;
  logic signed [QW-1:0]     tq_r_r, tq_r_nxt;
  logic signed [15:0]       le_r, le_nxt;
  logic signed [15:0]       re_r, re_nxt;
  logic [16:0]              kpe_r, kpe_nxt;
  logic signed [SW-1:0]     sum_r, sum_nxt;
  logic signed [AW-1:0]     acc_r, acc_nxt;

  logic signed [dwsp_pkg::PROD_W-1:0] p;
  logic [15:0]              kp_w;
  logic [15:0]              ki_w;
  logic signed [15:0]       err_w;
  logic signed [15:0]       prev_w;
  logic signed [31:0]       accum_w;
  logic signed [AW-1:0]     lim;
  logic signed [AW-1:0]     neg_lim;
  logic signed [AW-1:0]     clamp_v;
  logic signed [AW-1:0]     steer_sum;
  logic signed [QW-1:0]     tone;
  logic signed [QW-1:0]     steer_q;
  logic [3:0]               calm_inc;
  logic                     lower;
  logic signed [32:0]       lip;
  logic signed [32:0]       rip;
  logic signed [32:0]       sip;

  dwsp_mul u_mul (
    .clk (clk),
    .a   (op_a_r),
    .b   (op_b_r),
    .p   (p)
  );

  assign kp_w    = w_r ? cfg.right_kp : cfg.left_kp;
  assign ki_w    = w_r ? cfg.right_ki : cfg.left_ki;
  assign err_w   = w_r ? re_r : le_r;
  assign prev_w  = w_r ? rprev_r : lprev_r;
  assign accum_w = w_r ? racc_r : lacc_r;

  assign lim       = AW'({cfg.max_duty, {F{1'b0}}});
  assign neg_lim   = -lim;
  assign clamp_v   = (acc_r > lim) ? lim : ((acc_r < neg_lim) ? neg_lim : acc_r);
  assign steer_sum = AW'(steer_acc_r) + sc_r;
  assign tone      = QW'({t_r, {F{1'b0}}});
  assign steer_q   = QW'(steer_acc_r);
  assign calm_inc  = calm_r + 4'd1;
  assign lower     = (brake_r || ring_r) && (cfg.base_speed != 16'd0);

  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    e_nxt          = e_r;
    upd_nxt        = upd_r;
    ring_nxt       = ring_r;
    lc_nxt         = lc_r;
    rc_nxt         = rc_r;
    steer_prev_nxt = steer_prev_r;
    steer_acc_nxt  = steer_acc_r;
    lprev_nxt      = lprev_r;
    rprev_nxt      = rprev_r;
    lacc_nxt       = lacc_r;
    racc_nxt       = racc_r;
    brake_nxt      = brake_r;
    calm_nxt       = calm_r;
    op_a_nxt       = op_a_r;
    op_b_nxt       = op_b_r;
    sc_nxt         = sc_r;
    t_nxt          = t_r;
    tq_l_nxt       = tq_l_r;
    tq_r_nxt       = tq_r_r;
    le_nxt         = le_r;
    re_nxt         = re_r;
    kpe_nxt        = kpe_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          e_nxt    = item.line_error;
          upd_nxt  = item.turn_update;
          ring_nxt = item.ring_active;
          lc_nxt   = item.left_dir_pin ? 17'($signed(item.left_count))
                                       : -17'($signed(item.left_count));
          rc_nxt   = item.right_dir_pin ? -17'($signed(item.right_count))
                                        : 17'($signed(item.right_count));
          state_nxt = ST_STEER_OP;
        end
      end
      ST_STEER_OP: begin
        op_a_nxt = OW'(11'(e_r) - 11'(steer_prev_r));
        op_b_nxt = OW'(cfg.turn_kp);
        if (e_r > dwsp_pkg::BRAKE_HI || e_r < dwsp_pkg::BRAKE_LO) begin
          brake_nxt = 1'b1;
        end else if (calm_inc >= dwsp_pkg::CALM_LIMIT) begin
          brake_nxt = 1'b0;
          calm_nxt  = 4'd0;
        end else begin
          calm_nxt  = calm_inc;
        end
        state_nxt = ST_STEER_MUL;
      end
      ST_STEER_MUL: begin
        state_nxt = ST_STEER_SCL;
      end
      ST_STEER_SCL: begin
        sc_nxt    = to_qf(SW'(p));
        t_nxt     = lower ? cfg.base_speed - 16'd1 : cfg.base_speed;
        state_nxt = ST_STEER_ACC;
      end
      ST_STEER_ACC: begin
        if (upd_r) begin
          if (steer_sum > S32_MAX) begin
            steer_acc_nxt = 32'sh7FFF_FFFF;
          end else if (steer_sum < S32_MIN) begin
            steer_acc_nxt = 32'sh8000_0000;
          end else begin
            steer_acc_nxt = steer_sum[31:0];
          end
          steer_prev_nxt = e_r;
        end
        state_nxt = ST_TGT;
      end
      ST_TGT: begin
        if (steer_acc_r[31]) begin
          tq_l_nxt = tone + steer_q;
          tq_r_nxt = tone <<< 1;
        end else begin
          tq_l_nxt = tone;
          tq_r_nxt = (tone <<< 1) - (steer_q <<< 1);
        end
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        tq_l_nxt  = tq_l_r - (QW'(lc_r) <<< F);
        tq_r_nxt  = tq_r_r - (QW'(rc_r) <<< F);
        state_nxt = ST_ERRT;
      end
      ST_ERRT: begin
        le_nxt    = sat16(qdiv(tq_l_r));
        re_nxt    = sat16(qdiv(tq_r_r));
        w_nxt     = 1'b0;
        state_nxt = ST_W_BOOST;
      end
      ST_W_BOOST: begin
        op_a_nxt  = OW'(kp_w);
        op_b_nxt  = dwsp_pkg::NEG_BOOST;
        state_nxt = ST_W_BMUL;
      end
      ST_W_BMUL: begin
        state_nxt = ST_W_KPE;
      end
      ST_W_KPE: begin
        kpe_nxt   = err_w[15] ? p[dwsp_pkg::BOOST_SHIFT +: 17] : 17'(kp_w);
        op_a_nxt  = OW'(ki_w);
        op_b_nxt  = OW'(err_w);
        state_nxt = ST_W_DIFF;
      end
      ST_W_DIFF: begin
        op_a_nxt  = OW'(kpe_r);
        op_b_nxt  = OW'(17'(err_w) - 17'(prev_w));
        state_nxt = ST_W_IPROD;
      end
      ST_W_IPROD: begin
        sum_nxt   = SW'(p);
        state_nxt = ST_W_PSUM;
      end
      ST_W_PSUM: begin
        sum_nxt   = sum_r + SW'(p);
        state_nxt = ST_W_SCALE;
      end
      ST_W_SCALE: begin
        sc_nxt    = to_qf(sum_r);
        state_nxt = ST_W_ACC;
      end
      ST_W_ACC: begin
        acc_nxt   = AW'(accum_w) + sc_r;
        state_nxt = ST_W_CLAMP;
      end
      ST_W_CLAMP: begin
        if (w_r) begin
          racc_nxt  = clamp_v[31:0];
          rprev_nxt = re_r;
          state_nxt = ST_FIN;
        end else begin
          lacc_nxt  = clamp_v[31:0];
          lprev_nxt = le_r;
          w_nxt     = 1'b1;
          state_nxt = ST_W_BOOST;
        end
      end
      ST_FIN: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      w_r          <= 1'b0;
      steer_prev_r <= '0;
      steer_acc_r  <= '0;
      lprev_r      <= '0;
      rprev_r      <= '0;
      lacc_r       <= '0;
      racc_r       <= '0;
      brake_r      <= 1'b0;
      calm_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      w_r          <= w_nxt;
      steer_prev_r <= steer_prev_nxt;
      steer_acc_r  <= steer_acc_nxt;
      lprev_r      <= lprev_nxt;
      rprev_r      <= rprev_nxt;
      lacc_r       <= lacc_nxt;
      racc_r       <= racc_nxt;
      brake_r      <= brake_nxt;
      calm_r       <= calm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r    <= e_nxt;
    upd_r  <= upd_nxt;
    ring_r <= ring_nxt;
    lc_r   <= lc_nxt;
    rc_r   <= rc_nxt;
    op_a_r <= op_a_nxt;
    op_b_r <= op_b_nxt;
    sc_r   <= sc_nxt;
    t_r    <= t_nxt;
    tq_l_r <= tq_l_nxt;
    tq_r_r <= tq_r_nxt;
    le_r   <= le_nxt;
    re_r   <= re_nxt;
    kpe_r  <= kpe_nxt;
    sum_r  <= sum_nxt;
    acc_r  <= acc_nxt;
  end

  assign lip = ipart(lacc_r);
  assign rip = ipart(racc_r);
  assign sip = ipart(steer_acc_r);

  always_comb begin
    result.left_duty  = lip[15:0];
    result.right_duty = rip[15:0];
    if (sip > P16_MAX) begin
      result.steer_value = 16'sh7FFF;
    end else if (sip < P16_MIN) begin
      result.steer_value = 16'sh8000;
    end else begin
      result.steer_value = sip[15:0];
    end
    result.braking = brake_r;
  end

  assign status.idle      = (state_r == ST_IDLE);
  assign status.res_valid = (state_r == ST_FIN);

`ifndef SYNTHESIS
  a_calm_range: assert property (@(posedge clk) disable iff (!rst_n)
    calm_r < dwsp_pkg::CALM_LIMIT)
    else $error("calm tick counter out of range");

  a_start_enters: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> state_r == ST_STEER_OP)
    else $error("request accepted but sequence did not start");

  a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> (AW'(lacc_r) <= lim && AW'(lacc_r) >= neg_lim &&
                             AW'(racc_r) <= lim && AW'(racc_r) >= neg_lim))
    else $error("wheel accumulator outside duty clamp");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !res_ready) |=>
      (state_r == ST_FIN && $stable(lacc_r) && $stable(racc_r) &&
       $stable(steer_acc_r) && $stable(brake_r)))
    else $error("result changed while waiting for output slot");
`endif

endmodule

// ----- hw/rtl/differential_wheel_speed_pi_top.sv -----
// ----------------------------------------------------------------------------
// differential_wheel_speed_pi_top
// steering loop plus two incremental pi wheel speed loops, one tick per request
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  cfg      cfg_wr_en            cfg_index, cfg_wdata
//  in       in_valid / in_stall  line error, flags, encoder counts, dir pins
//  out      out_valid / out_stall left/right duty, steer value, braking
//
//  the sequencer takes a new request only when idle, not while one is in flight;
//  it runs the shared 18x18 multiplier once for the steering loop and three
//  times per wheel, wheels one after the other
//  reset is synchronous: clears config, output valid, loop state and brake flag
//  a held result in the output register does not block the next request; its
//  result then waits in the sequencer until the output register frees
module differential_wheel_speed_pi_top #(
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [dwsp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dwsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [9:0]                    in_line_error,
  input  logic                                 in_turn_update,
  input  logic                                 in_ring_active,
  input  logic signed [15:0]                   in_left_count,
  input  logic signed [15:0]                   in_right_count,
  input  logic                                 in_left_dir_pin,
  input  logic                                 in_right_dir_pin,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [15:0]                   out_left_duty,
  output logic signed [15:0]                   out_right_duty,
  output logic signed [15:0]                   out_steer_value,
  output logic                                 out_braking
);

  dwsp_pkg::dwsp_cfg_t     cfg_r, cfg_nxt;
  dwsp_pkg::dwsp_item_t    item;
  dwsp_pkg::dwsp_status_t  status;
  dwsp_pkg::dwsp_result_t  result;
  dwsp_pkg::dwsp_result_t  res_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    start;
  logic                    res_ready;
  logic                    load;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        dwsp_pkg::REG_BASE_SPEED:   cfg_nxt.base_speed   = cfg_wdata;
        dwsp_pkg::REG_LEFT_KP:      cfg_nxt.left_kp      = cfg_wdata;
        dwsp_pkg::REG_LEFT_KI:      cfg_nxt.left_ki      = cfg_wdata;
        dwsp_pkg::REG_RIGHT_KP:     cfg_nxt.right_kp     = cfg_wdata;
        dwsp_pkg::REG_RIGHT_KI:     cfg_nxt.right_ki     = cfg_wdata;
        dwsp_pkg::REG_TURN_KP:      cfg_nxt.turn_kp      = cfg_wdata;
        dwsp_pkg::REG_MAX_DUTY:     cfg_nxt.max_duty     = cfg_wdata[14:0];
        default: begin
        end
      endcase
    end
  end

  assign item.line_error    = in_line_error;
  assign item.turn_update   = in_turn_update;
  assign item.ring_active   = in_ring_active;
  assign item.left_count    = in_left_count;
  assign item.right_count   = in_right_count;
  assign item.left_dir_pin  = in_left_dir_pin;
  assign item.right_dir_pin = in_right_dir_pin;

  assign in_stall  = !status.idle;
  assign start     = in_valid && status.idle;
  assign res_ready = !out_valid_r || !out_stall;
  assign load      = status.res_valid && res_ready;

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  dwsp_seq #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .item      (item),
    .cfg       (cfg_r),
    .res_ready (res_ready),
    .status    (status),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_duty   = res_r.left_duty;
  assign out_right_duty  = res_r.right_duty;
  assign out_steer_value = res_r.steer_value;
  assign out_braking     = res_r.braking;

endmodule
